[rtl/tbim_pkg.sv]
`timescale 1ns / 1ps

package tbim_pkg;

	// Number formats
	localparam int FRAC_BITS    = 16;
	localparam int FLD_W        = 24;                 // Q8.FRAC_BITS momentum component
	localparam int CFG_W        = 24;
	localparam int CNT_W        = 32;                 // histogram counter
	localparam int NUM_BINS_DEF = 100;

	// Shared multiplier and accumulator
	localparam int MUL_W  = FLD_W + 1;                // one spare bit for the pair sums
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = PROD_W + 2;

	// Square root: radicand and root widths
	localparam int RAD_W  = PROD_W;
	localparam int ROOT_W = RAD_W / 2;

	// Product schedule: four squares per particle, then four squares of pair sums
	localparam int N_FLD     = 8;
	localparam int N_AXES    = 4;
	localparam int MUL_STEPS = N_FLD + N_AXES;

	// Binning: bin = ((m - low) * scale) >> (FRAC_BITS + 8)
	localparam int BIN_SHIFT = FRAC_BITS + 8;

	// Register reset values: low edge 1.1 GeV, 100 bins over 30 MeV
	localparam logic [CFG_W-1:0] HIST_LOW_RST  = CFG_W'(((11 << FRAC_BITS) + 5) / 10);
	localparam logic [CFG_W-1:0] BIN_SCALE_RST = CFG_W'(853333);
	localparam logic [FLD_W-1:0] MASS_MAX      = '1;

	typedef enum logic {
		FUNC_EVENT = 1'b0,
		FUNC_READ  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		REG_HIST_LOW  = 2'd0,
		REG_BIN_SCALE = 2'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		FS_IN_RANGE = 3'd0,
		FS_UNDER    = 3'd1,
		FS_OVER     = 3'd2,
		FS_NONPHYS  = 3'd3,
		FS_READ     = 3'd4
	} fill_status_t;

	typedef struct packed {
		logic mul_en;     // register a new product
		logic acc_en;     // fold the previous product into the accumulator
		logic acc_load;   // start a new sum with this product
		logic acc_sub;    // subtract rather than add
	} mac_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;       // one cycle pulse, root valid
	} sq_stat_t;

endpackage

[rtl/two_body_invariant_mass_histogram_unit.sv]
`timescale 1ns / 1ps
// Event: 12 products on the shared multiplier, then a 25-step square root, the bin
// product and the range checks; a nonphysical pair goes straight to the result.
// Read: the result comes from one registered RAM read.
// One item at a time; in_ready returns the cycle after the result transfer. Reset
// loads default config, clears the edge counters and zeroes the bin RAM in one pass
// over every bin, with in_ready low.

module two_body_invariant_mass_histogram_unit #(
	parameter int NUM_BINS = tbim_pkg::NUM_BINS_DEF,
	localparam int BIN_W = $clog2(NUM_BINS + 2)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [1:0]                             cfg_index,
	input  logic [tbim_pkg::CFG_W-1:0]             cfg_data,
	// input items
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   func,
	input  logic [BIN_W-1:0]                       read_bin,
	input  logic signed [tbim_pkg::FLD_W-1:0]      proton_energy,
	input  logic signed [tbim_pkg::FLD_W-1:0]      proton_px,
	input  logic signed [tbim_pkg::FLD_W-1:0]      proton_py,
	input  logic signed [tbim_pkg::FLD_W-1:0]      proton_pz,
	input  logic signed [tbim_pkg::FLD_W-1:0]      pion_energy,
	input  logic signed [tbim_pkg::FLD_W-1:0]      pion_px,
	input  logic signed [tbim_pkg::FLD_W-1:0]      pion_py,
	input  logic signed [tbim_pkg::FLD_W-1:0]      pion_pz,
	// result items
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [tbim_pkg::FLD_W-1:0]             pair_mass,
	output logic [BIN_W-1:0]                       bin_index,
	output logic [2:0]                             fill_status,
	output logic [tbim_pkg::CNT_W-1:0]             bin_count
);

	import tbim_pkg::*;

	localparam int AW     = $clog2(NUM_BINS);
	localparam int STEP_W = $clog2(MUL_STEPS + 1);

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b00_0000_0001,
		ST_IDLE  = 10'b00_0000_0010,
		ST_MUL   = 10'b00_0000_0100,
		ST_ROOT0 = 10'b00_0000_1000,
		ST_ROOT  = 10'b00_0001_0000,
		ST_BMUL  = 10'b00_0010_0000,
		ST_BCHK  = 10'b00_0100_0000,
		ST_FETCH = 10'b00_1000_0000,
		ST_UPD   = 10'b01_0000_0000,
		ST_DONE  = 10'b10_0000_0000
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic [STEP_W-1:0]  step_j;
	logic [AW-1:0]      clr_q;
	logic               bad_q;
	logic [CNT_W-1:0]   uf_q;
	logic [CNT_W-1:0]   of_q;
	logic [CFG_W-1:0]   hist_low_q;
	logic [CFG_W-1:0]   bin_scale_q;

	logic signed [FLD_W-1:0] fld_q [N_FLD];
	logic               is_read_q;
	logic [FLD_W-1:0]   mass_q;
	logic [BIN_W-1:0]   idx_q;
	fill_status_t       status_q;
	logic [CNT_W-1:0]   count_q;

	logic               in_xfer;
	logic               out_xfer;
	mac_ctrl_t          mac_ctrl;
	logic signed [MUL_W-1:0]  op_a;
	logic signed [MUL_W-1:0]  op_b;
	logic signed [MUL_W-1:0]  pair_op;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc;
	logic               sq_start;
	logic [ROOT_W-1:0]  root;
	sq_stat_t           sq_stat;
	logic [FLD_W-1:0]   mass_sat;
	logic [FLD_W-1:0]   diff;
	logic               under;
	logic [FLD_W-1:0]   bin_raw;
	logic               over;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [CNT_W-1:0]   ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [CNT_W-1:0]   ram_rdata;
	logic [CNT_W-1:0]   bin_next;
	logic [CNT_W-1:0]   read_val;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid && out_ready;

	// Operand for the current step: a single component, or a pair sum
	assign pair_op = (step_q < STEP_W'(N_FLD)) ? MUL_W'(fld_q[0])
	                                           : MUL_W'(fld_q[0]) + MUL_W'(fld_q[N_AXES]);
	assign step_j  = step_q - 1'b1;
	assign diff    = mass_q - hist_low_q;
	assign under   = (mass_q < hist_low_q);
	assign bin_raw = prod[BIN_SHIFT + FLD_W - 1 : BIN_SHIFT];
	assign over    = (bin_raw >= FLD_W'(NUM_BINS));
	assign mass_sat = root[ROOT_W-1] ? MASS_MAX : root[FLD_W-1:0];
	assign bin_next = ram_rdata + 1'b1;

	// Shared multiplier control and operand select
	always_comb begin
		mac_ctrl = '0;
		op_a     = pair_op;
		op_b     = pair_op;
		if (state_q == ST_MUL) begin
			mac_ctrl.mul_en   = (step_q < STEP_W'(MUL_STEPS));
			mac_ctrl.acc_en   = (step_q != '0);
			mac_ctrl.acc_load = (step_j[1:0] == 2'b00);
			mac_ctrl.acc_sub  = (step_j[1:0] != 2'b00);
		end else if (state_q == ST_BMUL) begin
			mac_ctrl.mul_en = 1'b1;
			op_a = MUL_W'(diff);
			op_b = MUL_W'(bin_scale_q);
		end
	end

	assign sq_start = (state_q == ST_ROOT0) && !bad_q && !acc[ACC_W-1];

	// Bin RAM ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = bin_next;
		ram_raddr = idx_q[AW-1:0];
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_UPD) begin
			ram_we = !is_read_q;
		end else if (state_q == ST_BCHK) begin
			ram_raddr = bin_raw[AW-1:0];
		end
	end

	// Counter selected by a read
	always_comb begin
		priority if (idx_q < BIN_W'(NUM_BINS)) begin
			read_val = ram_rdata;
		end else if (idx_q == BIN_W'(NUM_BINS)) begin
			read_val = uf_q;
		end else if (idx_q == BIN_W'(NUM_BINS + 1)) begin
			read_val = of_q;
		end else begin
			read_val = '0;
		end
	end

	// Sequencer, edge counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			step_q      <= '0;
			clr_q       <= '0;
			bad_q       <= 1'b0;
			uf_q        <= '0;
			of_q        <= '0;
			hist_low_q  <= HIST_LOW_RST;
			bin_scale_q <= BIN_SCALE_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_HIST_LOW:  hist_low_q  <= cfg_data;
					REG_BIN_SCALE: bin_scale_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NUM_BINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						step_q  <= '0;
						bad_q   <= 1'b0;
						state_q <= (func == FUNC_READ) ? ST_FETCH : ST_MUL;
					end
				end
				ST_MUL: begin
					// sum of the previous group is complete when a new group starts
					if (mac_ctrl.acc_en && mac_ctrl.acc_load && step_q != STEP_W'(1)) begin
						bad_q <= bad_q | acc[ACC_W-1];
					end
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(MUL_STEPS)) begin
						state_q <= ST_ROOT0;
					end
				end
				ST_ROOT0: state_q <= sq_start ? ST_ROOT : ST_DONE;
				ST_ROOT: begin
					if (sq_stat.done) begin
						state_q <= ST_BMUL;
					end
				end
				ST_BMUL: begin
					if (under) begin
						uf_q    <= uf_q + 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_BCHK;
					end
				end
				ST_BCHK: begin
					if (over) begin
						of_q    <= of_q + 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_FETCH: state_q <= ST_UPD;
				ST_UPD:   state_q <= ST_DONE;
				ST_DONE: begin
					if (out_xfer) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Operands and result registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			fld_q[0]  <= proton_energy;
			fld_q[1]  <= proton_px;
			fld_q[2]  <= proton_py;
			fld_q[3]  <= proton_pz;
			fld_q[4]  <= pion_energy;
			fld_q[5]  <= pion_px;
			fld_q[6]  <= pion_py;
			fld_q[7]  <= pion_pz;
			is_read_q <= (func == FUNC_READ);
			mass_q    <= '0;
			idx_q     <= read_bin;
			status_q  <= FS_READ;
			count_q   <= '0;
		end
		// rotate the components past the multiplier
		if (mac_ctrl.mul_en && state_q == ST_MUL) begin
			for (int i = 0; i < N_FLD - 1; i++) begin
				fld_q[i] <= fld_q[i+1];
			end
			fld_q[N_FLD-1] <= fld_q[0];
		end
		if (state_q == ST_ROOT0 && !sq_start) begin
			idx_q    <= '0;
			status_q <= FS_NONPHYS;
			count_q  <= '0;
		end
		if (state_q == ST_ROOT && sq_stat.done) begin
			mass_q <= mass_sat;
		end
		if (state_q == ST_BMUL && under) begin
			idx_q    <= BIN_W'(NUM_BINS);
			status_q <= FS_UNDER;
			count_q  <= uf_q + 1'b1;
		end
		if (state_q == ST_BCHK) begin
			if (over) begin
				idx_q    <= BIN_W'(NUM_BINS + 1);
				status_q <= FS_OVER;
				count_q  <= of_q + 1'b1;
			end else begin
				idx_q    <= BIN_W'(bin_raw[AW-1:0]);
				status_q <= FS_IN_RANGE;
			end
		end
		if (state_q == ST_UPD) begin
			count_q <= is_read_q ? read_val : bin_next;
		end
	end

	tbim_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod),
		.acc  (acc)
	);

	tbim_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (acc[RAD_W-1:0]),
		.root   (root),
		.stat   (sq_stat)
	);

	tbim_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign pair_mass   = mass_q;
	assign bin_index   = idx_q;
	assign fill_status = status_q;
	assign bin_count   = count_q;

	// Checks
	a_root_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		sq_stat.done |-> state_q == ST_ROOT)
		else $error("square root finished outside its wait state");

	a_ram_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_UPD))
		else $error("bin RAM written outside clear or update");

	a_nonphys_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_q == FS_NONPHYS) |-> (mass_q == '0 && count_q == '0))
		else $error("nonphysical result carries a mass or count");

	a_in_range_bin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_q == FS_IN_RANGE) |-> idx_q < BIN_W'(NUM_BINS))
		else $error("in-range result outside the bin range");

	a_sqrt_start_from_mul: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> $past(state_q) == ST_MUL)
		else $error("square root started without a finished product sum");

endmodule

[rtl/tbim_ram.sv]
`timescale 1ns / 1ps

module tbim_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/tbim_mac.sv]
`timescale 1ns / 1ps

module tbim_mac (
	input  logic                                clk,
	input  tbim_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [tbim_pkg::MUL_W-1:0]   op_a,
	input  logic signed [tbim_pkg::MUL_W-1:0]   op_b,
	output logic signed [tbim_pkg::PROD_W-1:0]  prod,
	output logic signed [tbim_pkg::ACC_W-1:0]   acc
);

	import tbim_pkg::*;

	logic signed [PROD_W-1:0] mul_c;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  prod_x;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  acc_q;

	// Multiply, registered; the add works on the stored product
	assign mul_c  = op_a * op_b;
	assign prod_x = ACC_W'(prod_q);
	assign term   = ctrl.acc_sub ? -prod_x : prod_x;
	assign base   = ctrl.acc_load ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= mul_c;
		end
		if (ctrl.acc_en) begin
			acc_q <= base + term;
		end
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule

[rtl/tbim_sqrt.sv]
`timescale 1ns / 1ps

module tbim_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tbim_pkg::RAD_W-1:0]        rad,
	output logic [tbim_pkg::ROOT_W-1:0]       root,
	output tbim_pkg::sq_stat_t                stat
);

	import tbim_pkg::*;

	localparam int REM_W = ROOT_W + 4;
	localparam int IT_W  = $clog2(ROOT_W);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [IT_W-1:0]   it_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_n;
	logic [REM_W-1:0]  trial;
	logic              fits;

	// One root bit per cycle, two radicand bits brought down each step
	assign rem_n = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial = REM_W'({root_q, 2'b01});
	assign fits  = (rem_n >= trial);

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				if (it_q == IT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				it_q <= it_q + 1'b1;
			end
		end
	end

	// Remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_n - trial) : rem_n;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
	import tbim_pkg::*;

	localparam int N_BINS = NUM_BINS_DEF;
	localparam int BIN_W = $clog2(N_BINS + 2);
	localparam int SCALE_SHIFT = 24;
	localparam logic [CFG_W-1:0] HIST_LOW_DEF = 24'd72090;
	localparam logic [CFG_W-1:0] BIN_SCALE_DEF = 24'd853333;
	localparam longint E_MAX = 64'sd8388607;
	localparam longint E_MIN = -64'sd8388608;
	localparam longint MASS_TOP = 2 * E_MAX;
	localparam longint unsigned MASS_SAT = 64'hFF_FFFF;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// one event or counter read as offered on the input channel
	typedef struct packed {
		func_t                    func;
		logic [BIN_W-1:0]         read_bin;
		logic signed [FLD_W-1:0]  e1;
		logic signed [FLD_W-1:0]  x1;
		logic signed [FLD_W-1:0]  y1;
		logic signed [FLD_W-1:0]  z1;
		logic signed [FLD_W-1:0]  e2;
		logic signed [FLD_W-1:0]  x2;
		logic signed [FLD_W-1:0]  y2;
		logic signed [FLD_W-1:0]  z2;
	} mh_item_t;

	typedef struct packed {
		logic [FLD_W-1:0]  mass;
		logic [BIN_W-1:0]  bin;
		fill_status_t      status;
		logic [CNT_W-1:0]  count;
	} mh_result_t;

	// Histogram predictor and result checker
	class mass_hist_sb;
		logic [CFG_W-1:0]  low_edge;
		logic [CFG_W-1:0]  scale;
		logic [CNT_W-1:0]  bin_counts [N_BINS];
		logic [CNT_W-1:0]  under_count;
		logic [CNT_W-1:0]  over_count;
		mh_result_t        pending [$];
		int                errors;
		int                events_in;
		int                reads_in;
		int                status_seen [5];

		function new();
			low_edge = HIST_LOW_DEF;
			scale = BIN_SCALE_DEF;
			foreach (bin_counts[i]) bin_counts[i] = '0;
			under_count = '0;
			over_count = '0;
			errors = 0;
			events_in = 0;
			reads_in = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		// floor square root, one result bit per pass from the top
		static function longint unsigned floor_sqrt(longint unsigned v);
			longint unsigned root;
			longint unsigned trial;
			root = 0;
			for (int i = 31; i >= 0; i--) begin
				trial = root | (64'd1 << i);
				if (trial * trial <= v)
					root = trial;
			end
			return root;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] d);
			case (idx)
			REG_HIST_LOW: begin
				low_edge = d;
			end
			REG_BIN_SCALE: begin
				scale = d;
			end
			default: begin
			end
			endcase
		endfunction

		// work out the result of an accepted transfer and update the histogram
		function void note_input(mh_item_t it);
			mh_result_t r;
			longint e1, x1, y1, z1, e2, x2, y2, z2;
			longint msq1, msq2, msq;
			longint unsigned m, b;
			r = '0;
			if (it.func == FUNC_READ) begin
				reads_in++;
				r.status = FS_READ;
				r.bin = it.read_bin;
				if (it.read_bin < N_BINS)
					r.count = bin_counts[it.read_bin];
				else if (it.read_bin == N_BINS)
					r.count = under_count;
				else if (it.read_bin == N_BINS + 1)
					r.count = over_count;
			end else begin
				events_in++;
				e1 = it.e1; x1 = it.x1; y1 = it.y1; z1 = it.z1;
				e2 = it.e2; x2 = it.x2; y2 = it.y2; z2 = it.z2;
				msq1 = e1 * e1 - (x1 * x1 + y1 * y1 + z1 * z1);
				msq2 = e2 * e2 - (x2 * x2 + y2 * y2 + z2 * z2);
				msq = msq1 + msq2 + 2 * (e1 * e2) - 2 * (x1 * x2 + y1 * y2 + z1 * z2);
				if (msq1 < 0 || msq2 < 0 || msq < 0) begin
					r.status = FS_NONPHYS;
				end else begin
					m = floor_sqrt(msq);
					if (m > MASS_SAT)
						m = MASS_SAT;
					r.mass = m[FLD_W-1:0];
					if (m < low_edge) begin
						under_count++;
						r.status = FS_UNDER;
						r.bin = BIN_W'(N_BINS);
						r.count = under_count;
					end else begin
						b = ((m - low_edge) * scale) >> SCALE_SHIFT;
						if (b >= N_BINS) begin
							over_count++;
							r.status = FS_OVER;
							r.bin = BIN_W'(N_BINS + 1);
							r.count = over_count;
						end else begin
							bin_counts[b]++;
							r.status = FS_IN_RANGE;
							r.bin = BIN_W'(b);
							r.count = bin_counts[b];
						end
					end
				end
			end
			pending.push_back(r);
		endfunction

		function void mismatch(string what, longint unsigned want, longint unsigned got);
			errors++;
			$display("%0t: %s expected 0x%0h actual 0x%0h", $time, what, want, got);
		endfunction

		function void check_result(mh_result_t got);
			mh_result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with nothing outstanding: mass 0x%0h bin %0d status %0d count %0d",
					$time, got.mass, got.bin, got.status, got.count);
				return;
			end
			want = pending.pop_front();
			status_seen[want.status]++;
			if (got.mass !== want.mass)
				mismatch("pair_mass", want.mass, got.mass);
			if (got.bin !== want.bin)
				mismatch("bin_index", want.bin, got.bin);
			if (got.status !== want.status)
				mismatch("fill_status", want.status, got.status);
			if (got.count !== want.count)
				mismatch("bin_count", want.count, got.count);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic func;
	logic [BIN_W-1:0] read_bin;
	logic signed [FLD_W-1:0] proton_energy;
	logic signed [FLD_W-1:0] proton_px;
	logic signed [FLD_W-1:0] proton_py;
	logic signed [FLD_W-1:0] proton_pz;
	logic signed [FLD_W-1:0] pion_energy;
	logic signed [FLD_W-1:0] pion_px;
	logic signed [FLD_W-1:0] pion_py;
	logic signed [FLD_W-1:0] pion_pz;
	logic out_valid;
	logic out_ready;
	logic [FLD_W-1:0] pair_mass;
	logic [BIN_W-1:0] bin_index;
	logic [2:0] fill_status;
	logic [CNT_W-1:0] bin_count;

	mass_hist_sb sb;
	idle_mode_t idle_mode;
	int hold_request;
	int reg_writes;

	two_body_invariant_mass_histogram_unit DUT (.*);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_pct(bit rx_side);
		case (idle_mode)
		IDLE_SEND: begin
			return rx_side ? 0 : 61;
		end
		IDLE_RECV: begin
			return rx_side ? 61 : 0;
		end
		IDLE_BOTH: begin
			return 7;
		end
		default: begin
			return 0;
		end
		endcase
	endfunction

	// Result side: random stalls, plus a long hold-off when one is requested
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(99) >= idle_pct(1'b1));
			end
		end
	end

	// Result transfers are checked on the clock edge that moves them
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{pair_mass, bin_index, fill_status_t'(fill_status), bin_count});
	end

	// Stimulus builders
	function automatic mh_item_t noise_item();
		mh_item_t it;
		it.func = func_t'($urandom_range(1));
		it.read_bin = BIN_W'($urandom);
		it.e1 = FLD_W'($urandom);
		it.x1 = FLD_W'($urandom);
		it.y1 = FLD_W'($urandom);
		it.z1 = FLD_W'($urandom);
		it.e2 = FLD_W'($urandom);
		it.x2 = FLD_W'($urandom);
		it.y2 = FLD_W'($urandom);
		it.z2 = FLD_W'($urandom);
		return it;
	endfunction

	function automatic mh_item_t mk_read(int rb);
		mh_item_t it;
		it = noise_item();
		it.func = FUNC_READ;
		it.read_bin = BIN_W'(rb);
		return it;
	endfunction

	function automatic mh_item_t mk_event(longint e1, longint x1, longint y1, longint z1,
			longint e2, longint x2, longint y2, longint z2);
		mh_item_t it;
		it = noise_item();
		it.func = FUNC_EVENT;
		it.e1 = FLD_W'(e1); it.x1 = FLD_W'(x1); it.y1 = FLD_W'(y1); it.z1 = FLD_W'(z1);
		it.e2 = FLD_W'(e2); it.x2 = FLD_W'(x2); it.y2 = FLD_W'(y2); it.z2 = FLD_W'(z2);
		return it;
	endfunction

	// Back-to-back pair whose invariant mass is tgt before any kick or off-shell change; when
	// off_shell is set the first particle gets an energy just short of its momentum.
	function automatic mh_item_t make_pair(longint tgt, bit off_shell);
		longint lim, px, py, pz, p2, pm, lo, hi, e1, e2, jit;
		lim = (tgt >= 64) ? tgt / 8 : 0;
		px = longint'($urandom_range(32'(2 * lim))) - lim;
		py = longint'($urandom_range(32'(2 * lim))) - lim;
		pz = longint'($urandom_range(32'(2 * lim))) - lim;
		p2 = px * px + py * py + pz * pz;
		pm = longint'(mass_hist_sb::floor_sqrt(p2));
		if (pm * pm < p2)
			pm++;
		lo = (tgt - E_MAX > pm) ? tgt - E_MAX : pm;
		hi = (tgt - pm < E_MAX) ? tgt - pm : E_MAX;
		if (hi < lo) begin
			px = 0; py = 0; pz = 0; pm = 0;
			lo = (tgt > E_MAX) ? tgt - E_MAX : 0;
			hi = (tgt < E_MAX) ? tgt : E_MAX;
		end
		e1 = lo + longint'($urandom_range(32'(hi - lo)));
		e2 = tgt - e1;
		if (off_shell && pm > 0)
			e1 = pm - 1;
		// both energies negative gives the same mass
		if ($urandom_range(3) == 0) begin
			e1 = -e1;
			e2 = -e2;
		end
		// small kick on the second particle now and then
		jit = ($urandom_range(3) == 0) ? longint'($urandom_range(4)) - 2 : 0;
		return mk_event(e1, px, py, pz, e2, -px + jit, -py, -pz);
	endfunction

	// Mass target, mostly inside the current histogram range or close to its edges
	function automatic longint pick_mass();
		longint span, tgt;
		int r;
		span = (sb.scale == 0) ? MASS_TOP : ((longint'(N_BINS) << SCALE_SHIFT) / sb.scale + 1);
		if (span > MASS_TOP)
			span = MASS_TOP;
		r = $urandom_range(99);
		if (r < 70)
			tgt = longint'(sb.low_edge) + longint'($urandom_range(32'(span)));
		else if (r < 82)
			tgt = longint'(sb.low_edge) - longint'($urandom_range(32'(span / 8 + 2)));
		else if (r < 92)
			tgt = longint'(sb.low_edge) + span - 2 + longint'($urandom_range(32'(span / 8 + 2)));
		else
			tgt = longint'($urandom_range(32'(MASS_TOP)));
		if (tgt < 0)
			tgt = 0;
		if (tgt > MASS_TOP)
			tgt = MASS_TOP;
		return tgt;
	endfunction

	function automatic mh_item_t random_item();
		mh_item_t it;
		int r;
		r = $urandom_range(99);
		if (r < 15) begin
			it = mk_read($urandom_range(127));
			if ($urandom_range(4) != 0)
				it.read_bin = BIN_W'($urandom_range(N_BINS + 1));
		end else if (r < 25) begin
			it = noise_item();
			it.func = FUNC_EVENT;
		end else if (r < 28) begin
			it = mk_event(E_MIN, 0, 0, 0, E_MIN, 0, 0, 0);
		end else begin
			it = make_pair(pick_mass(), r < 36);
		end
		return it;
	endfunction

	// Channel drivers; each starts and ends just after a falling edge
	task automatic send_item(input mh_item_t it);
		while ($urandom_range(99) < idle_pct(1'b0))
			@(negedge clk);
		in_valid = 1'b1;
		func = it.func;
		read_bin = it.read_bin;
		proton_energy = it.e1;
		proton_px = it.x1;
		proton_py = it.y1;
		proton_pz = it.z1;
		pion_energy = it.e2;
		pion_px = it.x2;
		pion_py = it.y2;
		pion_pz = it.z2;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] d);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_idle();
		int guard;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
	endtask

	task automatic set_config(input logic [CFG_W-1:0] low, input logic [CFG_W-1:0] scale);
		wait_idle();
		write_reg(REG_HIST_LOW, low);
		write_reg(REG_BIN_SCALE, scale);
	endtask

	task automatic run_phase(input int n_items, input idle_mode_t mode);
		idle_mode = mode;
		for (int k = 0; k < n_items; k++)
			send_item(random_item());
	endtask

	// Run limit
	initial begin
		#10_000_000;
		$display("%0t: run limit reached with %0d results outstanding", $time, sb.pending.size());
		$display("*** FAILED ***");
		$finish;
	end

	// Main sequence
	initial begin : stimulus
		sb = new;
		idle_mode = IDLE_NONE;
		hold_request = 0;
		reg_writes = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_HIST_LOW;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_EVENT;
		read_bin = '0;
		proton_energy = '0;
		proton_px = '0;
		proton_py = '0;
		proton_pz = '0;
		pion_energy = '0;
		pion_px = '0;
		pion_py = '0;
		pion_pz = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty counters, edges of the range, saturation and nonphysical pairs
		send_item(mk_read(0));
		send_item(mk_read(N_BINS - 1));
		send_item(mk_read(N_BINS));
		send_item(mk_read(N_BINS + 1));
		send_item(mk_read(127));
		send_item(mk_event(0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk_event(E_MIN, 0, 0, 0, E_MIN, 0, 0, 0));
		send_item(mk_event(E_MAX, 0, 0, 0, E_MAX, 0, 0, 0));
		send_item(mk_event(E_MIN, E_MIN, 0, 0, E_MAX, E_MAX, 0, 0));
		send_item(mk_event(E_MIN, 0, E_MIN, 0, E_MIN, 0, 0, E_MIN));
		send_item(mk_event(E_MAX, 0, 0, E_MAX, E_MAX, E_MAX, 0, 0));
		send_item(mk_event(0, 1, 0, 0, 0, 0, 0, 0));
		send_item(mk_event(65536, 0, 0, 0, 0, 0, 0, -1));
		send_item(mk_event(1, 1, 0, 0, -1, 1, 0, 0));
		send_item(mk_event(36045, 0, 0, 0, 36045, 0, 0, 0));
		send_item(mk_event(36044, 0, 0, 0, 36045, 0, 0, 0));
		send_item(make_pair(74056, 1'b0));
		send_item(make_pair(74057, 1'b0));
		send_item(make_pair(73000, 1'b0));
		send_item(make_pair(73000, 1'b0));
		send_item(mk_read(46));
		send_item(mk_read(0));
		send_item(mk_read(N_BINS - 1));
		send_item(mk_read(N_BINS));
		send_item(mk_read(N_BINS + 1));

		// random phases over several histogram settings and idling patterns
		set_config(HIST_LOW_DEF, BIN_SCALE_DEF);
		run_phase(140, IDLE_SEND);
		set_config('0, '1);
		run_phase(140, IDLE_RECV);
		set_config('1, '0);
		run_phase(120, IDLE_BOTH);

		// long receiver hold-off with the sender still offering, then a full drain
		set_config(24'd65536, 24'd25600);
		hold_request = 300;
		run_phase(70, IDLE_NONE);
		wait_idle();
		run_phase(70, IDLE_NONE);

		set_config(CFG_W'($urandom_range(24'd131072)), CFG_W'($urandom_range(24'd4000000)));
		run_phase(140, IDLE_SEND);
		set_config('0, '0);
		run_phase(120, IDLE_RECV);
		set_config(24'd98304, 24'd3413332);
		run_phase(140, IDLE_NONE);
		set_config(HIST_LOW_DEF, BIN_SCALE_DEF);
		run_phase(150, IDLE_BOTH);

		// drain and report
		idle_mode = IDLE_NONE;
		wait_idle();
		repeat (60) @(posedge clk);
		if (sb.pending.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d expected results never arrived", $time, sb.pending.size());
		end
		$display("Covered %0d events and %0d counter reads across %0d register writes.",
			sb.events_in, sb.reads_in, reg_writes);
		$display("Outcomes: in range %0d, underflow %0d, overflow %0d, nonphysical %0d, read %0d",
			sb.status_seen[FS_IN_RANGE], sb.status_seen[FS_UNDER], sb.status_seen[FS_OVER],
			sb.status_seen[FS_NONPHYS], sb.status_seen[FS_READ]);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
rtl/tbim_pkg.sv
rtl/tbim_ram.sv
rtl/tbim_mac.sv
rtl/tbim_sqrt.sv
rtl/two_body_invariant_mass_histogram_unit.sv
dv/tb.sv
